[hdl/era_pkg.sv]
// Package with types and constants shared by the echo range averager modules.
`default_nettype none

package era_pkg;

  // Widths averaged per result; the mean is taken with a right shift.
  localparam int SAMPLE_BITS = 4;
  localparam int SAMPLES     = 1 << SAMPLE_BITS;

  localparam int CFG_BITS   = 16;
  localparam int AVG_BITS   = 16;
  localparam int INDEX_BITS = 1;

  // Configuration register indexes.
  localparam logic [INDEX_BITS-1:0] REG_TRIGGER_LENGTH = 1'd0;
  localparam logic [INDEX_BITS-1:0] REG_CLOSE_LIMIT    = 1'd1;

  typedef enum logic [1:0] {
    PHASE_IDLE   = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_SECOND = 2'd2
  } phase_t;

  typedef struct packed {
    logic                trigger_level;
    logic                collision_flag;
    logic                collision_event;
    logic                average_valid;
    logic [AVG_BITS-1:0] average_width;
    logic                measuring;
  } era_result_t;

endpackage

`default_nettype wire

[hdl/era_core.sv]
// Measurement state and single-pass next-state logic for one timer tick.
`default_nettype none

module era_core #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic                            echo_level,
  input  wire logic                            start_request,
  input  wire logic [era_pkg::CFG_BITS-1:0]    trigger_length,
  input  wire logic [era_pkg::CFG_BITS-1:0]    close_limit,
  output era_pkg::era_result_t                 result
);
  import era_pkg::*;

  localparam int SUM_BITS = COUNTER_BITS + SAMPLE_BITS;
  localparam int CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;
  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SAMPLE_BITS-1:0] LAST_SAMPLE = SAMPLE_BITS'(SAMPLES - 1);

  phase_t                  phase, phase_next;
  logic [COUNTER_BITS-1:0] tick_counter, tick_counter_next;
  logic [COUNTER_BITS-1:0] start_time, start_time_next;
  logic [SUM_BITS-1:0]     width_sum, width_sum_next;
  logic [SAMPLE_BITS-1:0]  sample_count, sample_count_next;
  logic                    previous_echo;
  logic                    trigger_reg, trigger_reg_next;
  logic                    led_reg, led_reg_next;
  logic [AVG_BITS-1:0]     last_average, last_average_next;

  logic [COUNTER_BITS-1:0] count_inc;
  logic [COUNTER_BITS-1:0] echo_width;
  logic [SUM_BITS-1:0]     sum_add;
  logic [COUNTER_BITS-1:0] average;
  logic [CMP_BITS-1:0]     average_ext;
  logic                    edge_seen;
  logic                    done;
  logic                    average_valid;
  logic                    collision_event;

  always_comb begin
    count_inc          = tick_counter + 1'b1;
    edge_seen          = (echo_level != previous_echo);
    done               = 1'b0;
    echo_width         = '0;
    average_valid      = 1'b0;
    collision_event    = 1'b0;
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    start_time_next    = start_time;
    width_sum_next     = width_sum;
    sample_count_next  = sample_count;
    trigger_reg_next   = trigger_reg;
    led_reg_next       = led_reg;
    last_average_next  = last_average;

    if (phase == PHASE_IDLE && start_request) begin
      tick_counter_next = '0;
      trigger_reg_next  = 1'b1;
      phase_next        = PHASE_FIRST;
    end else begin
      tick_counter_next = count_inc;
      if (CMP_BITS'(count_inc) == CMP_BITS'(trigger_length)) begin
        trigger_reg_next = 1'b0;
      end
      if (phase != PHASE_IDLE) begin
        // A counter wrap ends the measurement at the full count, even on an edge.
        if (count_inc == '0) begin
          echo_width = COUNT_MAX;
          done       = 1'b1;
        end else if (edge_seen) begin
          case (phase)
            PHASE_FIRST: begin
              start_time_next = count_inc;
              phase_next      = PHASE_SECOND;
            end
            PHASE_SECOND: begin
              echo_width = count_inc - start_time;
              done       = 1'b1;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end

    sum_add     = width_sum + SUM_BITS'(echo_width);
    average     = sum_add[SUM_BITS-1:SAMPLE_BITS];
    average_ext = CMP_BITS'(average);

    if (done) begin
      phase_next = PHASE_IDLE;
      if (sample_count == LAST_SAMPLE) begin
        average_valid      = 1'b1;
        last_average_next  = average_ext[AVG_BITS-1:0];
        collision_event    = (average_ext < CMP_BITS'(close_limit));
        led_reg_next       = collision_event;
        width_sum_next     = '0;
        sample_count_next  = '0;
      end else begin
        width_sum_next     = sum_add;
        sample_count_next  = sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_IDLE;
      tick_counter  <= '0;
      start_time    <= '0;
      width_sum     <= '0;
      sample_count  <= '0;
      previous_echo <= 1'b0;
      trigger_reg   <= 1'b0;
      led_reg       <= 1'b0;
      last_average  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      start_time    <= start_time_next;
      width_sum     <= width_sum_next;
      sample_count  <= sample_count_next;
      previous_echo <= echo_level;
      trigger_reg   <= trigger_reg_next;
      led_reg       <= led_reg_next;
      last_average  <= last_average_next;
    end
  end

  always_comb begin
    result.trigger_level   = trigger_reg_next;
    result.collision_flag  = led_reg_next;
    result.collision_event = collision_event;
    result.average_valid   = average_valid;
    result.average_width   = last_average_next;
    result.measuring       = (phase_next != PHASE_IDLE);
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    step && phase == PHASE_IDLE && start_request |=>
      trigger_reg && phase == PHASE_FIRST && tick_counter == '0)
    else $error("start transaction did not arm the measurement");

  assert property (@(posedge clk) disable iff (rst)
    step && result.collision_event |-> result.average_valid && result.collision_flag)
    else $error("collision event without a new average");

  assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(tick_counter) && $stable(phase) && $stable(width_sum))
    else $error("measurement state moved without a transaction");
`endif

endmodule

`default_nettype wire

[hdl/echo_range_averager_unit.sv]
// Top level of the echo range averager: stream ports, input and result registers.
//
//   channel  direction  transaction fields
//   s_*      in         echo_level, start_request (one per timer tick)
//   m_*      out        trigger, flag, event, average valid/width, measuring
//   cfg_*    in         trigger length and close limit writes
//
// One transaction per clock sustained while m_tready is high; a tick is held in the input register,
// then its result is registered on m_tdata, where it stays until it is taken.
// Reset is synchronous; it clears the measurement and loads the default registers.
// A stalled result holds the result register; the input register takes one more
// transaction, after which s_tready stays low until the result is taken.
`default_nettype none

module echo_range_averager_unit #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // Bits from low: echo_level, start_request, zero fill.
  input  wire logic [7:0]                       s_tdata,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // Bits from low: trigger_level, collision_flag, collision_event, average_valid,
  // average_width[15:0], measuring, zero fill.
  output      logic [23:0]                      m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [era_pkg::INDEX_BITS-1:0]   cfg_index,
  input  wire logic [era_pkg::CFG_BITS-1:0]     cfg_data
);
  import era_pkg::*;

  logic                trigger_length_is_set;
  logic [CFG_BITS-1:0] trigger_length;
  logic [CFG_BITS-1:0] close_limit;
  logic                in_valid;
  logic                in_echo;
  logic                in_start;
  logic                out_ready;
  logic                step;
  era_result_t         result;

  assign trigger_length_is_set = cfg_we && (cfg_index == REG_TRIGGER_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_length <= CFG_BITS'(240);
      close_limit    <= CFG_BITS'(1000);
    end else if (trigger_length_is_set) begin
      trigger_length <= cfg_data;
    end else if (cfg_we && cfg_index == REG_CLOSE_LIMIT) begin
      close_limit <= cfg_data;
    end
  end

  assign out_ready = !m_tvalid || m_tready;
  assign step      = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_echo  <= s_tdata[0];
      in_start <= s_tdata[1];
    end
  end

  era_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .echo_level    (in_echo),
    .start_request (in_start),
    .trigger_length(trigger_length),
    .close_limit   (close_limit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'b000, result.measuring, result.average_width, result.average_valid,
                  result.collision_event, result.collision_flag, result.trigger_level};
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed tick did not reach the result register");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_ready |=> in_valid && $stable(in_echo) && $stable(in_start))
    else $error("waiting tick lost from the input register");

  assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("empty input register refused a transaction");
`endif

endmodule

`default_nettype wire
